// File: design/tag_reader_frame_parser_top_macros.svh
// assertion macros for the tag reader frame parser checker
// no dependencies; the including module must provide aclk and aresetn
`ifndef TAG_READER_FRAME_PARSER_TOP_MACROS_SVH
`define TAG_READER_FRAME_PARSER_TOP_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define TRFP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("trfp port check failed");

// consequent checked in the cycle after the antecedent
`define TRFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("trfp port check failed");

`endif

// File: design/trfp_pkg.sv
// shared types and constants for the tag reader frame parser
// no dependencies
package trfp_pkg;

    localparam logic [7:0] HDR_BYTE  = 8'h7F;
    localparam logic [7:0] MIN_LEN   = 8'd2;
    localparam logic [7:0] CMD_CARD  = 8'h10;
    localparam logic [7:0] CMD_BLOCK = 8'h14;
    localparam logic [7:0] BLOCK_LEN = 8'h19;

    // frame bytes kept for decoding: command up to end of the data block
    localparam int STORE_LO = 2;
    localparam int STORE_HI = 25;

    // token opcodes passed from front to back
    localparam logic [1:0] OP_LEN  = 2'd0;
    localparam logic [1:0] OP_BODY = 2'd1;
    localparam logic [1:0] OP_LAST = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_BAD_SUM   = 3'd0;
    localparam logic [2:0] KIND_CARD      = 3'd1;
    localparam logic [2:0] KIND_BLOCK_OK  = 3'd2;
    localparam logic [2:0] KIND_BLOCK_ERR = 3'd3;
    localparam logic [2:0] KIND_OTHER     = 3'd4;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] idx;
        logic [7:0] data;
    } token_t;

    typedef struct packed {
        logic [2:0]  frame_kind;
        logic [7:0]  command_code;
        logic [15:0] card_type;
        logic [31:0] card_id;
        logic [63:0] block_first_half;
        logic [63:0] block_second_half;
    } result_t;

endpackage

// File: design/tag_reader_frame_parser_top.sv
// tag reader frame parser, top level
// depends on trfp_pkg, trfp_front, trfp_queue, trfp_back
//
// Input stream: one received link byte per transfer on s_tdata.
// The parser hunts for a 0x7F header, takes a length byte (2 to MAX_LENGTH)
// and then that many frame bytes; inside a frame every other 0x7F is dropped.
// Output stream: one transfer per completed frame. m_tuser carries the
// frame kind, m_tdata the command byte and the card or block fields, with
// fields that do not apply to the kind driven to zero.
// Throughput: one input byte per cycle while the queue has room. The front end
// classifies each byte in the cycle it is accepted; the back end retires one queued
// token a cycle unless a last token waits for the output. m_tvalid rises once the
// last frame byte has passed the queue and the result is registered as it pops.
// Reset: parser returns to header hunt and the kept frame bytes read as zero.
// Receiver stall: the result is held on m_tdata/m_tuser; the back end keeps
// taking the next frame until its last token, which waits at the head of the
// four-entry queue; once the queue is full s_tready drops.
module tag_reader_frame_parser_top #(
    parameter int MAX_LENGTH = 126
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [183:0] m_tdata,   // [7:0] command_code, [23:8] card_type,
                                    // [55:24] card_id, [119:56] block_first_half,
                                    // [183:120] block_second_half
    output logic [2:0]   m_tuser    // [2:0] frame_kind
);
    import trfp_pkg::*;

    logic    q_full, q_empty, q_push, q_pop;
    token_t  push_token, head_token;
    result_t result;

    trfp_front #(
        .MAX_LENGTH(MAX_LENGTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .in_ready (s_tready),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_token  (push_token)
    );

    trfp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_token (push_token),
        .pop        (q_pop),
        .head_token (head_token),
        .full       (q_full),
        .empty      (q_empty)
    );

    trfp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_token (head_token),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tuser = result.frame_kind;
    assign m_tdata = {result.block_second_half, result.block_first_half,
                      result.card_id, result.card_type, result.command_code};

endmodule

// File: design/trfp_front.sv
// front end: header hunt, length check, escape toggle and frame indexing
// depends on trfp_pkg
module trfp_front #(
    parameter int MAX_LENGTH = 126
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  logic [7:0]      in_byte,
    output logic            in_ready,
    input  logic            q_full,
    output logic            q_push,
    output trfp_pkg::token_t q_token
);
    import trfp_pkg::*;

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;
    localparam logic [7:0] MAX_LEN_B = 8'(MAX_LENGTH);

    logic [1:0] phase_reg, phase_next;
    logic       toggle_reg, toggle_next;
    logic [7:0] idx_reg, idx_next;
    logic [7:0] len_reg, len_next;
    logic       accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        phase_next  = phase_reg;
        toggle_next = toggle_reg;
        idx_next    = idx_reg;
        len_next    = len_reg;
        q_push      = 1'b0;
        q_token     = '{op: OP_BODY, idx: idx_reg, data: in_byte};
        if (accept) begin
            case (phase_reg)
                PH_LEN: begin
                    if (in_byte >= MIN_LEN && in_byte <= MAX_LEN_B) begin
                        len_next    = in_byte;
                        idx_next    = 8'd2;
                        toggle_next = 1'b0;
                        phase_next  = PH_BODY;
                        q_push      = 1'b1;
                        q_token.op  = OP_LEN;
                    end else begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_BODY: begin
                    if (in_byte == HDR_BYTE && !toggle_reg) begin
                        // first of an escaped pair is dropped
                        toggle_next = 1'b1;
                    end else begin
                        if (in_byte == HDR_BYTE) begin
                            toggle_next = 1'b0;
                        end
                        q_push   = 1'b1;
                        idx_next = idx_reg + 8'd1;
                        if (idx_reg == len_reg + 8'd1) begin
                            q_token.op = OP_LAST;
                            phase_next = PH_HUNT;
                        end
                    end
                end
                default: begin
                    phase_next = (in_byte == HDR_BYTE) ? PH_LEN : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HUNT;
            toggle_reg <= 1'b0;
            idx_reg    <= 8'd0;
            len_reg    <= 8'd0;
        end else begin
            phase_reg  <= phase_next;
            toggle_reg <= toggle_next;
            idx_reg    <= idx_next;
            len_reg    <= len_next;
        end
    end

endmodule

// File: design/trfp_queue.sv
// short token queue between the front and back ends
// depends on trfp_pkg
module trfp_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  trfp_pkg::token_t push_token,
    input  logic             pop,
    output trfp_pkg::token_t head_token,
    output logic             full,
    output logic             empty
);
    import trfp_pkg::*;

    token_t          entry_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_AW:0]   count_reg, count_next;

    assign full       = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign empty      = (count_reg == '0);
    assign head_token = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_token;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// File: design/trfp_back.sv
// back end: frame byte store, running checksum, decode and output register
// depends on trfp_pkg
module trfp_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  trfp_pkg::token_t  head_token,
    input  logic              q_empty,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output trfp_pkg::result_t out_result
);
    import trfp_pkg::*;

    logic [7:0] store_reg [STORE_LO:STORE_HI];
    logic [7:0] view      [STORE_LO:STORE_HI];
    logic [7:0] len_reg;
    logic [7:0] xor_reg;
    logic       out_valid_reg;
    result_t    result_reg, result_next;
    logic       out_free;
    logic       is_write;
    logic       is_last;

    assign out_free  = !out_valid_reg || out_ready;
    assign is_last   = head_token.op == OP_LAST;
    assign q_pop     = !q_empty && (!is_last || out_free);
    assign is_write  = q_pop && (head_token.op == OP_BODY || is_last);
    assign out_valid = out_valid_reg;
    assign out_result = result_reg;

    // store as it stands once the head byte is written
    always_comb begin
        for (int k = STORE_LO; k <= STORE_HI; k++) begin
            view[k] = (is_write && head_token.idx == 8'(k)) ? head_token.data : store_reg[k];
        end
    end

    always_comb begin
        result_next              = '0;
        result_next.command_code = view[2];
        if (xor_reg != head_token.data) begin
            result_next.frame_kind = KIND_BAD_SUM;
        end else if (view[2] == CMD_CARD) begin
            result_next.frame_kind = KIND_CARD;
            result_next.card_type  = {view[4], view[5]};
            result_next.card_id    = {view[6], view[7], view[8], view[9]};
        end else if (view[2] == CMD_BLOCK) begin
            if (len_reg == BLOCK_LEN) begin
                result_next.frame_kind        = KIND_BLOCK_OK;
                result_next.block_first_half  = {view[10], view[11], view[12], view[13],
                                                 view[14], view[15], view[16], view[17]};
                result_next.block_second_half = {view[18], view[19], view[20], view[21],
                                                 view[22], view[23], view[24], view[25]};
            end else begin
                result_next.frame_kind = KIND_BLOCK_ERR;
            end
        end else begin
            result_next.frame_kind = KIND_OTHER;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = STORE_LO; k <= STORE_HI; k++) begin
                store_reg[k] <= 8'd0;
            end
            len_reg       <= 8'd0;
            xor_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end else begin
            for (int k = STORE_LO; k <= STORE_HI; k++) begin
                store_reg[k] <= view[k];
            end
            if (q_pop) begin
                case (head_token.op)
                    OP_LEN: begin
                        len_reg <= head_token.data;
                        xor_reg <= head_token.data;
                    end
                    OP_BODY: begin
                        xor_reg <= xor_reg ^ head_token.data;
                    end
                    default: begin
                    end
                endcase
            end
            if (q_pop && is_last) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && is_last) begin
            result_reg <= result_next;
        end
    end

endmodule

// File: design/trfp_checker.sv
// port-level checks for the tag reader frame parser, bound to the top level
// depends on trfp_pkg and tag_reader_frame_parser_top_macros.svh
`include "tag_reader_frame_parser_top_macros.svh"

module trfp_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [183:0] m_tdata,
    input logic [2:0]   m_tuser
);
    import trfp_pkg::*;

    // a stalled result stays offered
    `TRFP_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)

    // card fields only for a card read
    `TRFP_ASSERT_SAME(a_card_zero, m_tvalid && m_tuser != KIND_CARD, m_tdata[55:8] == '0)

    // block fields only for a good block read
    `TRFP_ASSERT_SAME(a_block_zero, m_tvalid && m_tuser != KIND_BLOCK_OK, m_tdata[183:56] == '0)

    // card kind implies the card command
    `TRFP_ASSERT_SAME(a_card_cmd, m_tvalid && m_tuser == KIND_CARD, m_tdata[7:0] == CMD_CARD)

endmodule

bind tag_reader_frame_parser_top trfp_checker u_checker (.*);

// File: dv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for tag_reader_frame_parser_top: link bytes in, decoded frames out
// depends on trfp_pkg and the parser rtl; holds its own frame decoder to predict each result

module testbench;
    import trfp_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 4;
    localparam int FRAME_MAX    = 126;
    localparam int PHASE_BYTES  = 440;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_TAIL   = 8;
    localparam int LIMIT_CYCLES = 200_000;

    class frame_result_tracker;
        typedef enum bit [1:0] {PH_HUNT, PH_LENGTH, PH_BODY} phase_e;

        phase_e     phase;
        bit         toggle;
        int         widx;
        bit [7:0]   xsum;
        bit [7:0]   store [FRAME_MAX + 2];
        result_t    expected_frames [$];
        int         errors;

        function new();
            phase  = PH_HUNT;
            toggle = 1'b0;
            widx   = 0;
            xsum   = '0;
            errors = 0;
            foreach (store[i]) store[i] = '0;
        endfunction

        // bytes first..first+count-1 of the store, first byte on top
        function bit [63:0] be_bytes(int first, int count);
            bit [63:0] v;
            v = '0;
            for (int k = 0; k < count; k++) v = {v[55:0], store[first + k]};
            return v;
        endfunction

        function void decode_frame(bit [7:0] last);
            result_t r;
            r = '0;
            r.command_code = store[2];
            if (xsum != last) begin
                r.frame_kind = KIND_BAD_SUM;
            end else if (store[2] == CMD_CARD) begin
                r.frame_kind = KIND_CARD;
                r.card_type  = 16'(be_bytes(4, 2));
                r.card_id    = 32'(be_bytes(6, 4));
            end else if (store[2] == CMD_BLOCK) begin
                if (store[1] == BLOCK_LEN) begin
                    r.frame_kind        = KIND_BLOCK_OK;
                    r.block_first_half  = be_bytes(10, 8);
                    r.block_second_half = be_bytes(18, 8);
                end else begin
                    r.frame_kind = KIND_BLOCK_ERR;
                end
            end else begin
                r.frame_kind = KIND_OTHER;
            end
            expected_frames.push_back(r);
        endfunction

        function void note_rx_byte(bit [7:0] b);
            case (phase)
                PH_LENGTH: begin
                    if (b >= MIN_LEN && b <= FRAME_MAX) begin
                        store[1] = b;
                        widx     = 2;
                        xsum     = b;
                        toggle   = 1'b0;
                        phase    = PH_BODY;
                    end else begin
                        phase = PH_HUNT;
                    end
                end
                PH_BODY: begin
                    // first 0x7f of a pair is swallowed, the second kept
                    if (b == HDR_BYTE) begin
                        if (!toggle) begin
                            toggle = 1'b1;
                            return;
                        end
                        toggle = 1'b0;
                    end
                    store[widx] = b;
                    widx++;
                    if (widx >= int'(store[1]) + 2) begin
                        phase = PH_HUNT;
                        decode_frame(b);
                    end else begin
                        xsum ^= b;
                    end
                end
                default: begin
                    if (b == HDR_BYTE) begin
                        store[0] = b;
                        widx     = 1;
                        phase    = PH_LENGTH;
                    end else begin
                        phase = PH_HUNT;
                    end
                end
            endcase
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("%0t ns  %s: got %0h expected %0h", $time, what, got, want);
            errors++;
        endtask

        task check_frame_result(logic [183:0] data, logic [2:0] user);
            result_t want;
            if (expected_frames.size() == 0) begin
                report("result with nothing pending, frame_kind", 64'(user), '0);
                return;
            end
            want = expected_frames.pop_front();
            if (user !== want.frame_kind)
                report("frame_kind", 64'(user), 64'(want.frame_kind));
            if (data[7:0] !== want.command_code)
                report("command_code", 64'(data[7:0]), 64'(want.command_code));
            if (data[23:8] !== want.card_type)
                report("card_type", 64'(data[23:8]), 64'(want.card_type));
            if (data[55:24] !== want.card_id)
                report("card_id", 64'(data[55:24]), 64'(want.card_id));
            if (data[119:56] !== want.block_first_half)
                report("block_first_half", data[119:56], want.block_first_half);
            if (data[183:120] !== want.block_second_half)
                report("block_second_half", data[183:120], want.block_second_half);
        endtask

        function int pending_count();
            return expected_frames.size();
        endfunction
    endclass

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [183:0] m_tdata;
    logic [2:0]   m_tuser;

    logic         sink_hold      = 1'b0;
    int           src_idle_pct   = 0;
    int           sink_stall_pct = 0;
    int           bytes_sent     = 0;
    int unsigned  cycle_count    = 0;
    bit [7:0]     frame_body [$];
    frame_result_tracker tracker;

    int idle_pcts  [4] = '{0, 55, 0, 24};
    int stall_pcts [4] = '{0, 0, 55, 24};

    tag_reader_frame_parser_top #(
        .MAX_LENGTH (FRAME_MAX)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tag_reader_frame_parser_top: mismatch");
            $finish;
        end
    end

    // result side: check each transfer, then pick the next ready level
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_frame_result(m_tdata, m_tuser);
        m_tready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic send_byte(input bit [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.note_rx_byte(b);
        bytes_sent++;
    endtask

    // frame_body holds bytes 2..len; the checksum is appended here
    task automatic send_frame(input bit [7:0] len, input bit sum_ok, input int sloppy_pct);
        bit [7:0] sum;
        sum = len;
        foreach (frame_body[i]) sum ^= frame_body[i];
        if (!sum_ok) sum ^= 8'($urandom_range(1, 255));
        frame_body.push_back(sum);
        send_byte(HDR_BYTE);
        send_byte(len);
        foreach (frame_body[i]) begin
            send_byte(frame_body[i]);
            // payload 0x7f goes out doubled, now and then left single
            if (frame_body[i] == HDR_BYTE && $urandom_range(99) >= sloppy_pct)
                send_byte(HDR_BYTE);
        end
    endtask

    function automatic bit [7:0] payload_byte();
        case ($urandom_range(7))
            0:       return HDR_BYTE;
            1:       return 8'h00;
            2:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_random_frame();
        int       pick;
        bit [7:0] len;
        bit [7:0] cmd;
        pick = $urandom_range(99);
        if (pick < 30) begin
            cmd = CMD_CARD;
            len = 8'($urandom_range(2, 14));
        end else if (pick < 60) begin
            cmd = CMD_BLOCK;
            len = ($urandom_range(3) != 0) ? BLOCK_LEN : 8'($urandom_range(2, 40));
        end else if (pick < 97) begin
            cmd = payload_byte();
            len = 8'($urandom_range(2, 20));
        end else begin
            cmd = $urandom_range(1) ? CMD_CARD : CMD_BLOCK;
            len = 8'($urandom_range(FRAME_MAX - 20, FRAME_MAX));
        end
        frame_body = {};
        frame_body.push_back(cmd);
        for (int i = 3; i <= len; i++) frame_body.push_back(payload_byte());
        send_frame(len, $urandom_range(9) != 0, 5);
    endtask

    task automatic send_noise();
        int n;
        case ($urandom_range(3))
            0: begin
                n = $urandom_range(1, 3);
                repeat (n) send_byte(payload_byte());
            end
            1: begin
                send_byte(HDR_BYTE);
                send_byte($urandom_range(1) ? 8'($urandom_range(0, 1))
                                            : 8'($urandom_range(FRAME_MAX + 1, 255)));
            end
            2: begin
                // truncated frame, the parser swallows what follows
                send_byte(HDR_BYTE);
                send_byte(8'($urandom_range(2, 20)));
                n = $urandom_range(0, 3);
                repeat (n) send_byte(payload_byte());
            end
            default: send_byte(HDR_BYTE);
        endcase
    endtask

    task automatic wait_for_results();
        while (tracker.pending_count() != 0) @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);
    endtask

    initial begin
        int target;
        tracker = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // lengths outside the legal range: just below, far above, just above
        send_byte(HDR_BYTE);
        send_byte(8'd1);
        send_byte(HDR_BYTE);
        send_byte(8'hFF);
        send_byte(HDR_BYTE);
        send_byte(8'(FRAME_MAX + 1));
        // card read on a short frame, fields come from the cleared store
        frame_body = '{CMD_CARD};
        send_frame(8'd2, 1'b1, 0);
        // block command with an escaped payload byte and the wrong length
        frame_body = '{CMD_BLOCK, HDR_BYTE};
        send_frame(8'd3, 1'b1, 0);
        frame_body = '{CMD_BLOCK};
        send_frame(8'd2, 1'b0, 0);
        frame_body = '{8'hFF};
        send_frame(8'd2, 1'b1, 0);
        send_byte(8'h00);
        s_tvalid <= 1'b0;
        wait_for_results();

        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct   = idle_pcts[ph];
            sink_stall_pct = stall_pcts[ph];
            if (ph == 0) begin
                // long receiver hold while bytes keep coming
                fork
                    begin
                        sink_hold <= 1'b1;
                        repeat (LONG_HOLD) @(posedge aclk);
                        sink_hold <= 1'b0;
                    end
                join_none
            end
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) begin
                if ($urandom_range(3) == 0) send_noise();
                send_random_frame();
            end
            s_tvalid <= 1'b0;
            wait_for_results();
        end

        if (tracker.errors == 0)
            $display("tag_reader_frame_parser_top: match");
        else
            $display("tag_reader_frame_parser_top: mismatch");
        $finish;
    end

endmodule
